@@ hdl/lphm_pkg.sv @@
// Shared types, codes and sizes for the linear probe hash map unit.
`timescale 1ns / 1ps

package lphm_pkg;

    // Table geometry.
    localparam int SLOTS      = 256;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int MASK_W     = 8;
    localparam int COUNT_W    = 9;
    localparam int KEY_W      = 32;
    localparam int HASH_W     = 32;
    localparam int VALUE_W    = 64;
    localparam logic [MASK_W-1:0] MASK_RESET = {MASK_W{1'b1}};

    // Width wide enough for both sides of the load limit compare.
    localparam int LOAD_W = ((COUNT_W + 2) > (SLOT_W + 3)) ? (COUNT_W + 2) : (SLOT_W + 3);

    typedef enum logic [1:0] {
        FUNC_GET = 2'd0,
        FUNC_PUT = 2'd1,
        FUNC_DEL = 2'd2
    } func_t;

    typedef enum logic [2:0] {
        ST_HIT  = 3'd0,
        ST_MISS = 3'd1,
        ST_NEW  = 3'd2,
        ST_UPD  = 3'd3,
        ST_FULL = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        KIND_EMPTY = 2'd0,
        KIND_LIVE  = 2'd1,
        KIND_TOMB  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_FINISH
    } fsm_state_t;

    typedef struct packed {
        logic [1:0]         func;
        logic [KEY_W-1:0]   key_id;
        logic [HASH_W-1:0]  key_hash;
        logic [VALUE_W-1:0] write_value;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic [VALUE_W-1:0] read_value;
        logic [COUNT_W-1:0] live_count;
    } rsp_t;

    typedef struct packed {
        kind_t              kind;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } slot_rec_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        slot_rec_t         rec;
    } slot_wr_t;

endpackage

@@ hdl/lphm_slot_store.sv @@
// Slot record memory with per-slot valid bits that read as empty after reset.
`timescale 1ns / 1ps

module lphm_slot_store
    import lphm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  slot_wr_t          slot_wr,
    input  logic [SLOT_W-1:0] rd_addr,
    output slot_rec_t         rd_rec
);

    slot_rec_t slot_mem [SLOTS];
    logic      valid_reg [SLOTS];
    slot_rec_t rd_rec_reg;
    logic      rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (slot_wr.en)
        begin
            slot_mem[slot_wr.addr] <= slot_wr.rec;
        end
        rd_rec_reg <= slot_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (slot_wr.en)
            begin
                valid_reg[slot_wr.addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    // A slot never written since reset is empty; its key and value are don't care.
    always_comb
    begin
        rd_rec = rd_rec_reg;
        if (!rd_valid_reg)
        begin
            rd_rec.kind = KIND_EMPTY;
        end
    end

endmodule

@@ hdl/lphm_probe_fsm.sv @@
// Probe sequencer: walks slots one per cycle through a single key compare unit.
`timescale 1ns / 1ps

module lphm_probe_fsm
    import lphm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  req_t              req,
    input  logic [SLOT_W-1:0] mask,
    output logic              busy,
    output logic              res_valid,
    input  logic              res_take,
    output rsp_t              res,
    output slot_wr_t          slot_wr,
    output logic [SLOT_W-1:0] rd_addr,
    input  slot_rec_t         rd_rec
);

    fsm_state_t         state_reg, state_next;
    req_t               req_reg, req_next;
    logic [SLOT_W-1:0]  idx_reg, idx_next;
    logic [SLOT_W-1:0]  steps_reg, steps_next;
    logic               have_tomb_reg, have_tomb_next;
    logic [SLOT_W-1:0]  tomb_reg, tomb_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    rsp_t               res_reg, res_next;

    logic              is_empty;
    logic              is_tomb;
    logic              match;
    logic              last_step;
    logic              tomb_seen;
    logic [SLOT_W-1:0] tomb_idx;
    logic [SLOT_W-1:0] where;
    logic              avail;
    logic [SLOT_W-1:0] start_idx;
    logic [LOAD_W-1:0] load_lhs;
    logic [LOAD_W-1:0] mask_plus1;
    logic [LOAD_W-1:0] load_rhs;
    logic              over_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            have_tomb_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            have_tomb_reg <= have_tomb_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        idx_reg   <= idx_next;
        steps_reg <= steps_next;
        tomb_reg  <= tomb_next;
        res_reg   <= res_next;
    end

    // Shared compare unit, evaluated on the slot read in the previous cycle.
    assign is_empty  = (rd_rec.kind == KIND_EMPTY);
    assign is_tomb   = (rd_rec.kind == KIND_TOMB);
    assign match     = (rd_rec.kind == KIND_LIVE) && (rd_rec.key == req_reg.key_id);
    assign last_step = (steps_reg == mask);
    assign tomb_seen = have_tomb_reg || is_tomb;
    assign tomb_idx  = have_tomb_reg ? tomb_reg : idx_reg;
    assign where     = (match || (is_empty && !have_tomb_reg)) ? idx_reg : tomb_idx;
    assign avail     = match || is_empty || tomb_seen;
    assign start_idx = req.key_hash[SLOT_W-1:0] & mask;

    // Reject a new key when 4 * (count + 1) > 3 * (mask + 1).
    assign load_lhs   = LOAD_W'({count_reg, 2'b00}) + LOAD_W'(4);
    assign mask_plus1 = LOAD_W'(mask) + LOAD_W'(1);
    assign load_rhs   = (mask_plus1 << 1) + mask_plus1;
    assign over_load  = (load_lhs > load_rhs);

    assign busy      = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_FINISH);
    assign res       = res_reg;

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        idx_next       = idx_reg;
        steps_next     = steps_reg;
        have_tomb_next = have_tomb_reg;
        tomb_next      = tomb_reg;
        count_next     = count_reg;
        res_next       = res_reg;
        rd_addr        = idx_reg;
        slot_wr.en     = 1'b0;
        slot_wr.addr   = where;
        slot_wr.rec    = '{kind: KIND_LIVE, key: req_reg.key_id, value: req_reg.write_value};

        unique case (state_reg)
            S_IDLE:
            begin
                rd_addr = start_idx;
                if (start)
                begin
                    req_next            = req;
                    idx_next            = start_idx;
                    steps_next          = '0;
                    have_tomb_next      = 1'b0;
                    res_next.status     = ST_MISS;
                    res_next.read_value = '0;
                    res_next.live_count = count_reg;
                    if ((req.func == FUNC_PUT) ||
                        (((req.func == FUNC_GET) || (req.func == FUNC_DEL)) && (count_reg != '0)))
                    begin
                        state_next = S_CHECK;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
            end

            S_CHECK:
            begin
                if (is_empty || match || last_step)
                begin
                    state_next = S_FINISH;
                    unique case (req_reg.func)
                        FUNC_GET:
                        begin
                            if (match)
                            begin
                                res_next.status     = ST_HIT;
                                res_next.read_value = rd_rec.value;
                            end
                        end
                        FUNC_PUT:
                        begin
                            if (match)
                            begin
                                slot_wr.en      = 1'b1;
                                res_next.status = ST_UPD;
                            end
                            else if (over_load || !avail)
                            begin
                                res_next.status = ST_FULL;
                            end
                            else
                            begin
                                slot_wr.en      = 1'b1;
                                count_next      = count_reg + COUNT_W'(1);
                                res_next.status = ST_NEW;
                            end
                        end
                        FUNC_DEL:
                        begin
                            if (match)
                            begin
                                slot_wr.en       = 1'b1;
                                slot_wr.rec      = rd_rec;
                                slot_wr.rec.kind = KIND_TOMB;
                                count_next       = count_reg - COUNT_W'(1);
                                res_next.status  = ST_HIT;
                            end
                        end
                        default:
                        begin
                            res_next.status = ST_MISS;
                        end
                    endcase
                    res_next.live_count = count_next;
                end
                else
                begin
                    // Keep walking; remember the first tombstone passed.
                    if (is_tomb && !have_tomb_reg)
                    begin
                        tomb_next = idx_reg;
                    end
                    have_tomb_next = tomb_seen;
                    idx_next       = (idx_reg + SLOT_W'(1)) & mask;
                    steps_next     = steps_reg + SLOT_W'(1);
                    rd_addr        = idx_next;
                end
            end

            S_FINISH:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/linear_probe_hash_map_unit.sv @@
// Top level of the linear probe hash map unit: ports, mask register, result register.
`timescale 1ns / 1ps

// This unit is a key/value map with open addressing and linear probing over a
// store of SLOTS slot records. Each transaction on the input channel is a get, a
// put or a delete; each produces exactly one result transaction carrying a status,
// the value read by a get hit (zero otherwise) and the live entry count after the
// request. The unit handles one request at a time: it raises in_stall from the
// cycle after a request is taken until its result has moved into the output
// register. Each request probes P slots in turn, where P runs from 1 up to
// slot_mask + 1; the slot store delivers one registered slot read per cycle
// and the sequencer compares one key per cycle. A get or delete on an empty
// map, and an unused operation code, skip the probe. As the output register
// is separate from the sequencer, a new request can be
// taken while the previous result still waits on out_stall. Slots are empty after
// reset through per-slot valid bits, so there is no clearing pass. A put of a new
// key that would raise the count above three quarters of the slots in use is
// answered full; there is no growth. The slot_mask register (number of slots in
// use minus one, a power of two minus one) is written through the cfg channel,
// which is always ready, and should only be written while the unit is idle.
module linear_probe_hash_map_unit
    import lphm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  req_t              in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output rsp_t              out_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [MASK_W-1:0] cfg_data
);

    logic [MASK_W-1:0] slot_mask_reg, slot_mask_next;
    logic              out_valid_reg, out_valid_next;
    rsp_t              out_data_reg, out_data_next;

    logic              busy;
    logic              start;
    logic              res_valid;
    logic              res_take;
    rsp_t              res;
    slot_wr_t          slot_wr;
    logic [SLOT_W-1:0] rd_addr;
    slot_rec_t         rd_rec;
    logic [SLOT_W-1:0] mask_eff;

    // The mask register is always writable; software keeps writes to idle periods.
    assign cfg_ready = 1'b1;

    // Only the low bits that address the store take part in probing.
    assign mask_eff = SLOT_W'({{SLOT_W{1'b0}}, slot_mask_reg});

    // The sequencer takes a new request only when it is idle.
    assign in_stall = busy;
    assign start    = in_valid && !busy;

    // A finished result moves into the output register once that register is empty or is handing on its result.
    assign res_take = res_valid && (!out_valid_reg || !out_stall);

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        slot_mask_next = slot_mask_reg;
        if (cfg_valid && cfg_ready)
        begin
            slot_mask_next = cfg_data;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_mask_reg <= MASK_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            slot_mask_reg <= slot_mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    lphm_probe_fsm u_probe_fsm
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (in_data),
        .mask      (mask_eff),
        .busy      (busy),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res),
        .slot_wr   (slot_wr),
        .rd_addr   (rd_addr),
        .rd_rec    (rd_rec)
    );

    lphm_slot_store u_slot_store
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .slot_wr (slot_wr),
        .rd_addr (rd_addr),
        .rd_rec  (rd_rec)
    );

`ifndef ASSERT_OFF
    // Once a request is taken the unit is busy with it in the following cycle.
    a_busy_after_accept : assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("request accepted but unit not busy afterwards");

    // Only a hit can carry a nonzero read value.
    a_value_only_on_hit : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_data.read_value == '0) || (out_data.status == ST_HIT)))
        else $error("nonzero read value on a result that is not a hit");

    // The slot store is only written while a request is in progress.
    a_write_while_busy : assert property (@(posedge clk) disable iff (!rst_n)
        slot_wr.en |-> busy)
        else $error("slot store written while idle");

    // A new result never enters the output register without a finished request.
    a_result_source : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(res_valid))
        else $error("output became valid without a finished request");
`endif

endmodule
